/* sv/jrsl_pkg.sv */
// ----------------------------------------------------------------------------
// jrsl_pkg: shared types and constants of the joint reference slew limiter
// Fixed point formats, the queue record, configuration record, FSM codes and
// the limit clamp that both the front end and the back end use.
// ----------------------------------------------------------------------------
package jrsl_pkg;

	localparam int FRAC_BITS = 20;

	localparam int POS_W   = 32;
	localparam int DT_W    = 16;
	localparam int SPEED_W = 27;
	localparam int MFE_W   = 31;
	localparam int TIME_W  = 32;
	localparam int OP_W    = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// slew step = (max_speed * dt) >> FRAC_BITS
	localparam int PROD_W = SPEED_W + DT_W;
	localparam int STEP_W = PROD_W - FRAC_BITS;

	// working width of the back end; all intermediate positions fit
	localparam int X_W = 35;
	// wrap unit: offset input width, 2*pi width, quotient width
	localparam int U_W = X_W + 1;
	localparam int T_W = FRAC_BITS + 3;
	localparam int K_W = U_W - T_W + 1;

	localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;
	localparam logic [63:0] PI_FIX =
		(PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
	localparam logic [63:0] TWO_PI_FIX = PI_FIX << 1;
	localparam logic [63:0] PI_M1_FIX  = PI_FIX - 64'd1;
	// floor(2^U_W / 2pi): the quotient estimate is never high, at most one low
	localparam logic [63:0] RECIP_FIX  = (64'd1 << U_W) / TWO_PI_FIX;
	// multiple of 2pi above 2^(X_W-1), plus pi-1: makes the wrap input positive
	localparam logic [63:0] WRAP_OFS_FIX =
		TWO_PI_FIX * ((64'd1 << (X_W - 1)) / TWO_PI_FIX + 64'd1) + PI_M1_FIX;

	localparam logic [T_W-1:0] TWO_PI_T = TWO_PI_FIX[T_W-1:0];
	localparam logic [T_W-1:0] PI_M1_T  = PI_M1_FIX[T_W-1:0];
	localparam logic [K_W-1:0] RECIP_K  = RECIP_FIX[K_W-1:0];
	localparam logic [U_W-1:0] WRAP_OFS_U = WRAP_OFS_FIX[U_W-1:0];

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [OP_W-1:0] {
		OP_ENTER  = 2'd0,
		OP_TARGET = 2'd1,
		OP_STEP   = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOWER_LIMIT     = 3'd0,
		CFG_UPPER_LIMIT     = 3'd1,
		CFG_LIMITS_ENABLED  = 3'd2,
		CFG_CONTINUOUS      = 3'd3,
		CFG_MAX_SPEED       = 3'd4,
		CFG_MAX_FOLLOW_ERR  = 3'd5,
		CFG_COMMAND_TIMEOUT = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic signed [POS_W-1:0] lower_limit;
		logic signed [POS_W-1:0] upper_limit;
		logic                    limits_enabled;
		logic                    continuous_joint;
		logic [SPEED_W-1:0]      max_speed;
		logic [MFE_W-1:0]        follow_err_limit;
		logic [TIME_W-1:0]       command_timeout;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		lower_limit:         32'sh8000_0000,
		upper_limit:         32'sh7FFF_FFFF,
		limits_enabled:      1'b0,
		continuous_joint:    1'b0,
		max_speed:           '0,
		follow_err_limit:    '0,
		command_timeout:     '0
	};

	typedef enum logic {
		JOB_ENTER = 1'b0,
		JOB_STEP  = 1'b1
	} job_kind_t;

	typedef struct packed {
		job_kind_t               kind;
		logic signed [POS_W-1:0] pos;
		logic signed [POS_W-1:0] goal;
		logic                    stale;
		logic [STEP_W-1:0]       slew_step;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRAP_A,
		ST_WRAP_B,
		ST_WRAP_C,
		ST_WRAP_D,
		ST_WRAP_E,
		ST_SLEW,
		ST_LEAD,
		ST_LEASH,
		ST_FIN
	} back_state_t;

	typedef enum logic [1:0] {
		PASS_ERR,
		PASS_LEAD,
		PASS_FINAL
	} wrap_pass_t;

	// inverted limits: a value below the lower limit takes the lower limit, any other the upper
	function automatic logic signed [POS_W-1:0] clamp_limits(
		input logic signed [POS_W-1:0] x,
		input cfg_t                    c
	);
		logic signed [POS_W-1:0] r;
		r = x;
		if (c.limits_enabled) begin
			if (x < $signed(c.lower_limit)) begin
				r = c.lower_limit;
			end else if (x > $signed(c.upper_limit)) begin
				r = c.upper_limit;
			end
		end
		return r;
	endfunction

endpackage

/* sv/jrsl_cmd_if.sv */
// ----------------------------------------------------------------------------
// jrsl_cmd_if: command channel
// Valid/ready channel carrying one request: op, position and dt.
// ----------------------------------------------------------------------------
interface jrsl_cmd_if import jrsl_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         op;
	logic signed [POS_W-1:0] position;
	logic [DT_W-1:0]         dt;

	modport source (output valid, op, position, dt, input ready);
	modport sink   (input valid, op, position, dt, output ready);
endinterface

/* sv/jrsl_rsp_if.sv */
// ----------------------------------------------------------------------------
// jrsl_rsp_if: response channel
// Valid/ready channel carrying the new reference and the stale flag.
// ----------------------------------------------------------------------------
interface jrsl_rsp_if import jrsl_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] reference_position;
	logic                    stale;

	modport source (output valid, reference_position, stale, input ready);
	modport sink   (input valid, reference_position, stale, output ready);
endinterface

/* sv/jrsl_cfg_if.sv */
// ----------------------------------------------------------------------------
// jrsl_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface jrsl_cfg_if import jrsl_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* sv/jrsl_front.sv */
// ----------------------------------------------------------------------------
// jrsl_front: request intake and classification
// Owns the watchdog, hold and target state; resolves goal, stale flag and
// slew step for each step request and queues enter and step jobs.
// ----------------------------------------------------------------------------
module jrsl_front import jrsl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	jrsl_cmd_if.sink cmd,
	input  cfg_t     cfg,
	input  logic     full,
	output job_req_t wr
);

	logic signed [POS_W-1:0] hold_q;
	logic signed [POS_W-1:0] target_q;
	logic                    follow_q;
	logic [TIME_W-1:0]       elapsed_q;

	logic                    accept;
	logic [TIME_W:0]         elapsed_sum;
	logic [TIME_W-1:0]       elapsed_d;
	logic                    stale;
	logic signed [POS_W-1:0] sel;
	logic signed [POS_W-1:0] goal;
	logic [PROD_W-1:0]       prod;

	assign cmd.ready = !full;
	assign accept    = cmd.valid && cmd.ready;

	// saturating watchdog accumulate
	assign elapsed_sum = {1'b0, elapsed_q} + {{(TIME_W + 1 - DT_W){1'b0}}, cmd.dt};
	assign elapsed_d   = elapsed_sum[TIME_W] ? '1 : elapsed_sum[TIME_W-1:0];
	assign stale       = (cfg.command_timeout != '0) && (elapsed_d >= cfg.command_timeout);

	assign sel  = follow_q ? target_q : hold_q;
	assign goal = stale ? clamp_limits(cmd.position, cfg) : clamp_limits(sel, cfg);

	assign prod = {{DT_W{1'b0}}, cfg.max_speed} * {{SPEED_W{1'b0}}, cmd.dt};

	always_comb begin
		wr.valid         = accept && (cmd.op == OP_ENTER || cmd.op == OP_STEP);
		wr.job.kind      = (cmd.op == OP_STEP) ? JOB_STEP : JOB_ENTER;
		wr.job.pos       = cmd.position;
		wr.job.goal      = goal;
		wr.job.stale     = stale;
		wr.job.slew_step = prod[PROD_W-1:FRAC_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q    <= '0;
			target_q  <= '0;
			follow_q  <= 1'b0;
			elapsed_q <= '0;
		end else if (accept) begin
			unique case (cmd.op)
				OP_ENTER: begin
					hold_q    <= cmd.position;
					follow_q  <= 1'b0;
					elapsed_q <= '0;
				end
				OP_TARGET: begin
					target_q  <= cmd.position;
					follow_q  <= 1'b1;
					elapsed_q <= '0;
				end
				OP_STEP: begin
					elapsed_q <= elapsed_d;
				end
				default: ;
			endcase
		end
	end

endmodule

/* sv/jrsl_queue.sv */
// ----------------------------------------------------------------------------
// jrsl_queue: job queue between front end and back end
// Small flop FIFO; head is presented combinationally.
// ----------------------------------------------------------------------------
module jrsl_queue import jrsl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  job_req_t wr,
	output logic     full,
	input  logic     pop,
	output job_req_t rd
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
	localparam logic [QPTR_W:0]   CNT_FULL = (QPTR_W + 1)'(QUEUE_DEPTH);

	assign full     = (count_q == CNT_FULL);
	assign rd.valid = (count_q != '0);
	assign rd.job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr.valid) begin
			mem_q[wr_ptr_q] <= wr.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !wr.valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count above depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr.valid |-> !full)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> rd.valid)
		else $error("pop from empty queue");

endmodule

/* sv/jrsl_back.sv */
// ----------------------------------------------------------------------------
// jrsl_back: reference update sequencer
// Owns the reference; runs slew, leash if enabled, wrap on a continuous joint
// (shared multi-cycle unit), saturation and clamp per step job; holds the response.
// ----------------------------------------------------------------------------
module jrsl_back import jrsl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  job_req_t   head,
	output logic       pop,
	jrsl_rsp_if.source rsp
);

	back_state_t state_q, state_d;
	wrap_pass_t  pass_q, pass_d;

	logic signed [POS_W-1:0] ref_q;
	logic signed [X_W-1:0]   x_q;
	logic signed [POS_W-1:0] pos_q;
	logic [STEP_W-1:0]       step_q;
	logic                    stale_q;
	logic [U_W-1:0]          u_q;
	logic [K_W-1:0]          k_q;
	logic [U_W-1:0]          m_q;
	logic [T_W:0]            y_q;

	logic                    out_valid_q;
	logic signed [POS_W-1:0] out_ref_q;
	logic                    out_stale_q;

	logic                    out_free;
	logic                    fin_load;
	logic signed [POS_W-1:0] idle_base;
	logic [U_W+K_W-1:0]      recip_prod;
	logic [K_W+T_W-1:0]      km_prod;
	logic [U_W-1:0]          u_minus_m;
	logic [T_W:0]            y_sel;
	logic signed [X_W-1:0]   wrap_out;
	logic signed [X_W-1:0]   pos_x;
	logic signed [X_W-1:0]   step_x;
	logic signed [X_W-1:0]   mfe_x;
	logic signed [POS_W-1:0] sat_val;
	logic signed [POS_W-1:0] fin_val;

	localparam logic signed [X_W-1:0] SAT_MAX = {{(X_W - POS_W + 1){1'b0}}, {(POS_W - 1){1'b1}}};
	localparam logic signed [X_W-1:0] SAT_MIN = {{(X_W - POS_W + 1){1'b1}}, {(POS_W - 1){1'b0}}};

	function automatic logic signed [X_W-1:0] clamp_sym(
		input logic signed [X_W-1:0] x,
		input logic signed [X_W-1:0] m
	);
		logic signed [X_W-1:0] r;
		r = x;
		if (x > m) begin
			r = m;
		end else if (x < -m) begin
			r = -m;
		end
		return r;
	endfunction

	assign out_free = !out_valid_q || rsp.ready;

	// stale step restarts from the measured position
	assign idle_base = (head.job.kind == JOB_ENTER || head.job.stale) ? head.job.pos : ref_q;

	assign pos_x  = X_W'(pos_q);
	assign step_x = $signed(X_W'(step_q));
	assign mfe_x  = $signed(X_W'(cfg.follow_err_limit));

	// wrap unit: y = ((x + pi - 1) mod 2pi) - (pi - 1), into (-pi, pi]
	assign recip_prod = {{K_W{1'b0}}, u_q} * {{U_W{1'b0}}, RECIP_K};
	assign km_prod    = {{T_W{1'b0}}, k_q} * {{K_W{1'b0}}, TWO_PI_T};
	assign u_minus_m  = u_q - m_q;
	assign y_sel      = (y_q >= {1'b0, TWO_PI_T}) ? y_q - {1'b0, TWO_PI_T} : y_q;
	assign wrap_out   = $signed({{(X_W - T_W - 1){1'b0}}, y_sel})
		- $signed({{(X_W - T_W){1'b0}}, PI_M1_T});

	assign sat_val = (x_q > SAT_MAX) ? SAT_MAX[POS_W-1:0] :
		(x_q < SAT_MIN) ? SAT_MIN[POS_W-1:0] : x_q[POS_W-1:0];
	assign fin_val = clamp_limits(sat_val, cfg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= PASS_ERR;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pass_d   = pass_q;
		pop      = 1'b0;
		fin_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					if (head.job.kind == JOB_STEP) begin
						if (cfg.continuous_joint) begin
							state_d = ST_WRAP_A;
							pass_d  = PASS_ERR;
						end else begin
							state_d = ST_SLEW;
						end
					end
				end
			end
			ST_WRAP_A: state_d = ST_WRAP_B;
			ST_WRAP_B: state_d = ST_WRAP_C;
			ST_WRAP_C: state_d = ST_WRAP_D;
			ST_WRAP_D: state_d = ST_WRAP_E;
			ST_WRAP_E: begin
				unique case (pass_q)
					PASS_ERR:  state_d = ST_SLEW;
					PASS_LEAD: state_d = ST_LEASH;
					default:   state_d = ST_FIN;
				endcase
			end
			ST_SLEW: state_d = ST_LEAD;
			ST_LEAD: begin
				if (cfg.follow_err_limit != '0) begin
					if (cfg.continuous_joint) begin
						state_d = ST_WRAP_A;
						pass_d  = PASS_LEAD;
					end else begin
						state_d = ST_LEASH;
					end
				end else if (cfg.continuous_joint) begin
					state_d = ST_WRAP_A;
					pass_d  = PASS_FINAL;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_LEASH: begin
				if (cfg.continuous_joint) begin
					state_d = ST_WRAP_A;
					pass_d  = PASS_FINAL;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					fin_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= '0;
		end else if (state_q == ST_IDLE && head.valid) begin
			ref_q <= idle_base;
		end else if (fin_load) begin
			ref_q <= fin_val;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					x_q     <= X_W'(head.job.goal) - X_W'(idle_base);
					pos_q   <= head.job.pos;
					step_q  <= head.job.slew_step;
					stale_q <= head.job.stale;
				end
			end
			ST_WRAP_A: u_q <= U_W'(x_q) + WRAP_OFS_U;
			ST_WRAP_B: k_q <= recip_prod[U_W+K_W-1:U_W];
			ST_WRAP_C: m_q <= km_prod[U_W-1:0];
			ST_WRAP_D: y_q <= u_minus_m[T_W:0];
			ST_WRAP_E: x_q <= wrap_out;
			ST_SLEW:   x_q <= X_W'(ref_q) + clamp_sym(x_q, step_x);
			ST_LEAD: begin
				if (cfg.follow_err_limit != '0) begin
					x_q <= x_q - pos_x;
				end
			end
			ST_LEASH:  x_q <= pos_x + clamp_sym(x_q, mfe_x);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_ref_q   <= fin_val;
			out_stale_q <= stale_q;
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.reference_position = out_ref_q;
	assign rsp.stale              = out_stale_q;

	a_fin_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_load && cfg.limits_enabled
			&& $signed(cfg.lower_limit) <= $signed(cfg.upper_limit))
		|-> (fin_val >= $signed(cfg.lower_limit) && fin_val <= $signed(cfg.upper_limit)))
		else $error("reference outside enabled limits");

	a_ref_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !head.valid) |=> $stable(ref_q))
		else $error("reference moved with no job");

	a_fin_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !out_free) |=> (state_q == ST_FIN && $stable(out_ref_q)))
		else $error("response overwritten while stalled");

endmodule

/* sv/joint_reference_slew_limiter_core.sv */
// ----------------------------------------------------------------------------
// joint_reference_slew_limiter_core: one-joint position reference generator
//
// cmd carries requests: op enter (take measured position as hold and as the
// reference), op target (new target), op step (advance the reference).
// Op code three is dropped. Only steps produce a response on rsp:
// the new reference and the watchdog stale flag. cfg writes registers by
// index; it is always ready and is meant to be used while the block is idle.
//
// cmd is accepted every cycle while the 4-entry job queue has room. A step
// leaves the queue into the back-end sequencer, which owns the reference and
// so takes one step at a time: slew, lead, the following-error leash when
// enabled, then the final saturate and clamp. A continuous joint also wraps
// the error before the slew, the lead before the leash and the result at the
// end, each wrap in states WRAP_A to WRAP_E of the shared wrap unit. An enter
// only sets the reference in the sequencer; a target never enters the queue.
// Reset clears config to defaults, state to zero and empties the queue.
// When rsp stalls, the response register holds, the sequencer waits, the
// queue fills and cmd.ready drops.
// ----------------------------------------------------------------------------
module joint_reference_slew_limiter_core import jrsl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	jrsl_cmd_if.sink   cmd,
	jrsl_rsp_if.source rsp,
	jrsl_cfg_if.sink   cfg
);

	cfg_t     cfg_q;
	job_req_t wr;
	job_req_t head;
	logic     full;
	logic     pop;

	// register file: never backpressures
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_LOWER_LIMIT:     cfg_q.lower_limit      <= cfg.data;
				CFG_UPPER_LIMIT:     cfg_q.upper_limit      <= cfg.data;
				CFG_LIMITS_ENABLED:  cfg_q.limits_enabled   <= cfg.data[0];
				CFG_CONTINUOUS:      cfg_q.continuous_joint <= cfg.data[0];
				CFG_MAX_SPEED:       cfg_q.max_speed        <= cfg.data[SPEED_W-1:0];
				CFG_MAX_FOLLOW_ERR:  cfg_q.follow_err_limit <= cfg.data[MFE_W-1:0];
				CFG_COMMAND_TIMEOUT: cfg_q.command_timeout  <= cfg.data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// front: watchdog, goal selection and clamp, slew step product
	jrsl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg_q),
		.full   (full),
		.wr     (wr)
	);

	// decouples intake from the multi-cycle reference update
	jrsl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.full   (full),
		.pop    (pop),
		.rd     (head)
	);

	// back: slew, leash, wrap, saturate, clamp; response register
	jrsl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

/* tb/jrsl_reference_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrsl_reference_checker: reference predictor and response check
// Watches the cfg, cmd and rsp channels. Keeps its own registers and joint
// state, predicts the reference and stale flag of every accepted step, and
// checks each response against the oldest prediction.
// ----------------------------------------------------------------------------
module jrsl_reference_checker import jrsl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	jrsl_cmd_if  cmd,
	jrsl_rsp_if  rsp,
	jrsl_cfg_if  cfg,
	output int   mismatches,
	output int   outstanding
);

	typedef struct packed {
		logic signed [POS_W-1:0] reference_position;
		logic                    stale;
	} joint_ref_t;

	localparam logic [63:0] TURN_Q60 = 64'h3243_F6A8_885A_308D;
	localparam longint HALF_TURN =
		longint'((TURN_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
	localparam longint FULL_TURN = 2 * HALF_TURN;
	localparam longint POS_MAX = 64'sd2147483647;
	localparam longint POS_MIN = -64'sd2147483648;

	// registers
	longint            lim_lo, lim_hi, speed, leash;
	bit                lim_on, wraps;
	logic [TIME_W-1:0] stale_after;

	// joint state
	longint            joint_ref, hold_pos, target_pos;
	bit                chase_target;
	logic [TIME_W-1:0] since_command;

	joint_ref_t ref_queue[$];
	int         fail_count;

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// into (-pi, pi]
	function automatic longint wrap_turn(input longint x);
		longint r;
		r = x % FULL_TURN;
		if (r > HALF_TURN) r -= FULL_TURN;
		if (r <= -HALF_TURN) r += FULL_TURN;
		return r;
	endfunction

	function automatic longint clamp_mag(input longint x, input longint m);
		if (x > m) return m;
		if (x < -m) return -m;
		return x;
	endfunction

	// inverted pair: a value below the lower limit takes the lower limit, any other the upper
	function automatic longint clamp_to_limits(input longint x);
		if (!lim_on) return x;
		if (x < lim_lo) return lim_lo;
		if (x > lim_hi) return lim_hi;
		return x;
	endfunction

	// updates the joint state; returns 1 when the request yields a response
	function automatic bit advance_joint(
		input  logic [OP_W-1:0]  op,
		input  longint           pos,
		input  logic [DT_W-1:0]  dt,
		output joint_ref_t       res
	);
		logic [TIME_W:0] sum;
		bit              frozen;
		longint          goal, err, step, r, lead;
		res = '0;
		case (op)
		OP_ENTER: begin
			hold_pos      = pos;
			joint_ref     = pos;
			chase_target  = 1'b0;
			since_command = '0;
			return 1'b0;
		end
		OP_TARGET: begin
			target_pos    = pos;
			chase_target  = 1'b1;
			since_command = '0;
			return 1'b0;
		end
		OP_STEP: ;
		default: return 1'b0;
		endcase

		sum = {1'b0, since_command} + {{(TIME_W + 1 - DT_W){1'b0}}, dt};
		since_command = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
		frozen = (stale_after != '0) && (since_command >= stale_after);

		if (frozen) begin
			joint_ref = pos;
			goal      = pos;
		end else begin
			goal = chase_target ? target_pos : hold_pos;
		end
		goal = clamp_to_limits(goal);

		err = goal - joint_ref;
		if (wraps) err = wrap_turn(err);
		step = (speed * longint'(dt)) >>> FRAC_BITS;
		r = joint_ref + clamp_mag(err, step);

		if (leash > 0) begin
			lead = r - pos;
			if (wraps) lead = wrap_turn(lead);
			r = pos + clamp_mag(lead, leash);
		end
		if (wraps) r = wrap_turn(r);
		if (r > POS_MAX) r = POS_MAX;
		if (r < POS_MIN) r = POS_MIN;
		r = clamp_to_limits(r);
		joint_ref = r;

		res.reference_position = r[POS_W-1:0];
		res.stale              = frozen;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		joint_ref_t got, want;
		if (!arst_n) begin
			lim_lo        = POS_MIN;
			lim_hi        = POS_MAX;
			lim_on        = 1'b0;
			wraps         = 1'b0;
			speed         = 0;
			leash         = 0;
			stale_after   = '0;
			joint_ref     = 0;
			hold_pos      = 0;
			target_pos    = 0;
			chase_target  = 1'b0;
			since_command = '0;
			ref_queue.delete();
			fail_count    = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				CFG_LOWER_LIMIT:     lim_lo = longint'($signed(cfg.data));
				CFG_UPPER_LIMIT:     lim_hi = longint'($signed(cfg.data));
				CFG_LIMITS_ENABLED:  lim_on = cfg.data[0];
				CFG_CONTINUOUS:      wraps = cfg.data[0];
				CFG_MAX_SPEED:       speed = longint'(cfg.data[SPEED_W-1:0]);
				CFG_MAX_FOLLOW_ERR:  leash = longint'(cfg.data[MFE_W-1:0]);
				CFG_COMMAND_TIMEOUT: stale_after = cfg.data;
				default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (ref_queue.size() == 0) begin
					report_mismatch($sformatf("response %0d/%0b with none pending",
						rsp.reference_position, rsp.stale));
				end else begin
					want = ref_queue.pop_front();
					if (rsp.reference_position !== want.reference_position) begin
						report_mismatch($sformatf("reference_position %0d, expected %0d",
							rsp.reference_position, want.reference_position));
					end
					if (rsp.stale !== want.stale) begin
						report_mismatch($sformatf("stale %b, expected %b",
							rsp.stale, want.stale));
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				if (advance_joint(cmd.op, longint'(cmd.position), cmd.dt, got)) begin
					ref_queue.push_back(got);
				end
			end
		end
		mismatches  <= fail_count;
		outstanding <= ref_queue.size();
	end

endmodule

/* tb/joint_reference_slew_limiter_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_reference_slew_limiter_core_tb: testbench of the joint reference core
// Drives cmd and cfg, throttles rsp, and leaves prediction and comparison to
// jrsl_reference_checker. Runs a directed pass over limits, watchdog and wrap
// corners, random phases under random register setups, and a short gap-free
// tail with the watchdog armed at its largest timeout.
// ----------------------------------------------------------------------------
module joint_reference_slew_limiter_core_tb import jrsl_pkg::*; ();

	// covers the longest step (continuous joint with leash) plus queued enters
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 56;
	// full-length steps in the gap-free tail
	localparam int TAIL_STEPS    = 24;

	// index with no register behind it, op code the block drops
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
	localparam logic [OP_W-1:0]      OP_SPARE      = 2'd3;

	localparam logic [DT_W-1:0]         DT_MAX     = '1;
	localparam logic signed [POS_W-1:0] POS_TOP    = 32'sh7FFF_FFFF;
	localparam logic signed [POS_W-1:0] POS_BOTTOM = 32'sh8000_0000;
	localparam logic signed [POS_W-1:0] PI_POS     = PI_FIX[POS_W-1:0];

	logic clk;
	logic arst_n;

	jrsl_cmd_if cmd();
	jrsl_rsp_if rsp();
	jrsl_cfg_if cfg();

	int mismatches;
	int outstanding;

	bit idling;         // random gaps on both sides
	bit calm;           // final stretch: no gaps at all
	bit long_hold_req;  // asks the response side for one long stall

	joint_reference_slew_limiter_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	jrsl_reference_checker reference_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rsp         (rsp),
		.cfg         (cfg),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Response side: ready with random stall bursts; one long hold-off on
	// request so the job queue fills and cmd.ready drops.
	// ------------------------------------------------------------------
	initial begin : rsp_side
		int hold;
		rsp.ready <= 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = 400;
			end
			if (hold > 0) begin
				rsp.ready <= 1'b0;
				hold--;
			end else if (idling && !calm && $urandom_range(0, 9) == 0) begin
				rsp.ready <= 1'b0;
				hold = $urandom_range(0, 16);
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Request helpers. valid is only raised here; it is dropped by a gap,
	// at a drain, or after a register batch, never in the same step.
	// ------------------------------------------------------------------
	task automatic write_reg(
		input logic [CFG_IDX_W-1:0]  idx,
		input logic [CFG_DATA_W-1:0] value
	);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic send_request(
		input logic [OP_W-1:0]         op,
		input logic signed [POS_W-1:0] pos,
		input logic [DT_W-1:0]         dt
	);
		cmd.valid    <= 1'b1;
		cmd.op       <= op;
		cmd.position <= pos;
		cmd.dt       <= dt;
		do @(posedge clk); while (!cmd.ready);
		if (idling && !calm && $urandom_range(0, 7) == 0) begin
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// wait out all responses, then enough cycles for trailing enters
	task automatic drain_and_wait();
		cmd.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic cfg_t make_setup(
		input logic signed [POS_W-1:0] lo,
		input logic signed [POS_W-1:0] hi,
		input logic                    en,
		input logic                    cont,
		input logic [SPEED_W-1:0]      spd,
		input logic [MFE_W-1:0]        mfe,
		input logic [TIME_W-1:0]       tmo
	);
		cfg_t c;
		c.lower_limit      = lo;
		c.upper_limit      = hi;
		c.limits_enabled   = en;
		c.continuous_joint = cont;
		c.max_speed        = spd;
		c.follow_err_limit = mfe;
		c.command_timeout  = tmo;
		return c;
	endfunction

	// unused data bits get random junk; the block must ignore them
	task automatic load_setup(input cfg_t c);
		write_reg(CFG_LOWER_LIMIT, c.lower_limit);
		write_reg(CFG_UPPER_LIMIT, c.upper_limit);
		write_reg(CFG_LIMITS_ENABLED, (32'($urandom()) & 32'hFFFF_FFFE) | c.limits_enabled);
		if ($urandom_range(0, 1) != 0) begin
			write_reg(CFG_SPARE_IDX, $urandom());
		end
		write_reg(CFG_CONTINUOUS, (32'($urandom()) & 32'hFFFF_FFFE) | c.continuous_joint);
		write_reg(CFG_MAX_SPEED, {5'($urandom()), c.max_speed});
		write_reg(CFG_MAX_FOLLOW_ERR, {1'($urandom()), c.follow_err_limit});
		write_reg(CFG_COMMAND_TIMEOUT, c.command_timeout);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic signed [POS_W-1:0] sample_position(
		input logic signed [POS_W-1:0] around
	);
		case ($urandom_range(0, 9))
		0: return $urandom();
		1: return ($urandom_range(0, 1) != 0) ? POS_TOP : POS_BOTTOM;
		2, 3, 4: return around + $signed($urandom_range(0, 400000)) - 200000;
		default: return $signed($urandom_range(0, 8000000)) - 4000000;
		endcase
	endfunction

	function automatic logic [DT_W-1:0] sample_dt();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return DT_MAX;
		2, 3, 4, 5: return DT_W'($urandom_range(1, 2000));
		default: return DT_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// random setup with the extremes of every register in the mix
	function automatic cfg_t pick_setup();
		cfg_t                    c;
		logic signed [POS_W-1:0] base;
		int                      span;
		base = $signed($urandom_range(0, 8000000)) - 4000000;
		span = $urandom_range(0, 4000000);
		case ($urandom_range(0, 3))
		0: begin
			c.lower_limit = POS_BOTTOM;
			c.upper_limit = POS_TOP;
		end
		1: begin
			c.lower_limit = base;
			c.upper_limit = base + span;
		end
		2: begin
			// inverted pair
			c.lower_limit = base + span + 1;
			c.upper_limit = base;
		end
		default: begin
			c.lower_limit = $urandom();
			c.upper_limit = $urandom();
		end
		endcase
		c.limits_enabled   = $urandom_range(0, 3) != 0;
		c.continuous_joint = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 3))
		0: c.max_speed = '0;
		1: c.max_speed = '1;
		2: c.max_speed = SPEED_W'($urandom_range(1, 1 << 23));
		default: c.max_speed = SPEED_W'($urandom());
		endcase
		case ($urandom_range(0, 3))
		0: c.follow_err_limit = '0;
		1: c.follow_err_limit = '1;
		2: c.follow_err_limit = MFE_W'($urandom_range(1, 1 << 21));
		default: c.follow_err_limit = MFE_W'($urandom());
		endcase
		case ($urandom_range(0, 3))
		0: c.command_timeout = '0;
		1: c.command_timeout = '1;
		default: c.command_timeout = $urandom_range(1, 400000);
		endcase
		return c;
	endfunction

	// mostly well-formed control sequences (enter, target, a run of steps
	// with a drifting measurement), with some raw noise requests mixed in
	task automatic run_random_phase(input int budget);
		int                      sent;
		logic signed [POS_W-1:0] meas;
		sent = 0;
		meas = sample_position(32'sd0);
		while (sent < budget) begin
			if ($urandom_range(0, 6) == 0) begin
				send_request(OP_W'($urandom_range(0, 3)), $urandom(), DT_W'($urandom()));
				sent++;
			end else begin
				meas = sample_position(meas);
				if ($urandom_range(0, 3) != 0) begin
					send_request(OP_ENTER, meas, sample_dt());
					sent++;
				end
				if ($urandom_range(0, 2) != 0) begin
					send_request(OP_TARGET, sample_position(meas), sample_dt());
					sent++;
				end
				repeat ($urandom_range(1, 8)) begin
					meas = meas + $signed($urandom_range(0, 20000)) - 10000;
					send_request(OP_STEP, meas, sample_dt());
					sent++;
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus and verdict
	// ------------------------------------------------------------------
	initial begin : stimulus
		cmd.valid    <= 1'b0;
		cmd.op       <= OP_ENTER;
		cmd.position <= '0;
		cmd.dt       <= '0;
		cfg.valid    <= 1'b0;
		cfg.index    <= CFG_LOWER_LIMIT;
		cfg.data     <= '0;
		idling       = 1'b1;
		calm         = 1'b0;
		arst_n       <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: zero speed pins the reference at zero; the
		// spare op code must leave no trace
		send_request(OP_STEP, 32'sd12345, 16'd100);
		send_request(OP_SPARE, POS_TOP, DT_MAX);
		send_request(OP_STEP, POS_BOTTOM, DT_MAX);
		drain_and_wait();

		// position clamps at full slew rate, goals far outside the range
		load_setup(make_setup(-32'sd1000000, 32'sd1000000, 1'b1, 1'b0, '1, '0, '0));
		send_request(OP_ENTER, POS_TOP, '0);
		send_request(OP_STEP, POS_TOP, DT_MAX);
		send_request(OP_TARGET, POS_BOTTOM, '0);
		send_request(OP_STEP, POS_BOTTOM, DT_MAX);
		send_request(OP_STEP, 32'sd0, '0);
		drain_and_wait();

		// inverted limits, leash of one count, watchdog of one tick:
		// fresh with dt 0, stale from the first tick on
		load_setup(make_setup(32'sd500, -32'sd500, 1'b1, 1'b0, '1, 31'd1, 32'd1));
		send_request(OP_TARGET, 32'sd0, '0);
		send_request(OP_STEP, 32'sd0, '0);
		send_request(OP_STEP, POS_TOP, 16'd1);
		send_request(OP_STEP, POS_BOTTOM, '0);
		drain_and_wait();

		// continuous joint: short way round, wrap of far positions, +/- pi
		load_setup(make_setup(POS_BOTTOM, POS_TOP, 1'b0, 1'b1, '1, 31'd1000, '0));
		send_request(OP_ENTER, 32'sd3000000, '0);
		send_request(OP_TARGET, -32'sd3000000, '0);
		send_request(OP_STEP, 32'sd3000000, DT_MAX);
		send_request(OP_STEP, POS_BOTTOM, 16'd1000);
		send_request(OP_TARGET, POS_TOP, '0);
		send_request(OP_STEP, PI_POS, 16'd500);
		send_request(OP_STEP, -PI_POS, 16'd500);

		// random phases; every third runs without gaps, the second one
		// includes a long response stall
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_and_wait();
			load_setup(pick_setup());
			idling = (p % 3) != 2;
			if (p == 1) long_hold_req = 1'b1;
			run_random_phase(PHASE_ITEMS);
		end

		// gap-free tail: watchdog armed at all ones stays fresh; an enter
		// clears the elapsed time again
		drain_and_wait();
		calm = 1'b1;
		load_setup(make_setup(POS_BOTTOM, POS_TOP, 1'b0, 1'b0, 27'd1000, '0, '1));
		send_request(OP_ENTER, 32'sd0, '0);
		repeat (TAIL_STEPS) begin
			send_request(OP_STEP, sample_position(32'sd0), DT_MAX);
		end
		send_request(OP_ENTER, 32'sd777, '0);
		send_request(OP_STEP, 32'sd777, DT_MAX);

		drain_and_wait();
		if (mismatches == 0 && outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* joint_reference_slew_limiter_core.f */
sv/jrsl_pkg.sv
sv/jrsl_cmd_if.sv
sv/jrsl_rsp_if.sv
sv/jrsl_cfg_if.sv
sv/jrsl_front.sv
sv/jrsl_queue.sv
sv/jrsl_back.sv
sv/joint_reference_slew_limiter_core.sv
tb/jrsl_reference_checker.sv
tb/joint_reference_slew_limiter_core_tb.sv
